// File: src/iso_ts_pkg.sv
// Shared types, character codes and constants for the ISO 8601 timestamp parser.
// No dependencies; imported by the parser top level and its port checker.
`default_nettype none

package iso_ts_pkg;

	localparam int unsigned EPOCH_W = 39;
	localparam int unsigned TDATA_W = 40;
	localparam int unsigned ACC_W   = 40;

	// head layout YYYY-MM-DDTHH:MM:SS
	localparam logic [4:0] HEAD_LEN   = 5'd19;
	localparam logic [4:0] POS_DASH1  = 5'd4;
	localparam logic [4:0] POS_DASH2  = 5'd7;
	localparam logic [4:0] POS_SEP    = 5'd10;
	localparam logic [4:0] POS_COLON1 = 5'd13;
	localparam logic [4:0] POS_COLON2 = 5'd16;

	localparam logic [7:0] CH_DASH  = 8'h2D;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_T_UC  = 8'h54;
	localparam logic [7:0] CH_T_LC  = 8'h74;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_Z_UC  = 8'h5A;
	localparam logic [7:0] CH_Z_LC  = 8'h7A;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	// offset match counts
	localparam logic [2:0] OFS_PREFIX_END = 3'd3;
	localparam logic [2:0] OFS_AFTER_HH   = 3'd4;
	localparam logic [2:0] OFS_COMPACT_END = 3'd5;
	localparam logic [2:0] OFS_COLON_END  = 3'd6;

	// field limits
	localparam logic [6:0] MONTH_MAX  = 7'd12;
	localparam logic [6:0] DAY_MAX    = 7'd31;
	localparam logic [6:0] HOUR_MAX   = 7'd23;
	localparam logic [6:0] MINUTE_MAX = 7'd59;
	localparam logic [6:0] SECOND_MAX = 7'd60;

	// conversion constants
	localparam logic [16:0] RECIP_25      = 17'd5243;  // ceil(2^17 / 25)
	localparam int unsigned RECIP_SHIFT   = 17;
	localparam logic [16:0] DAY_SECS      = 17'd86400;
	localparam logic [16:0] HOUR_SECS     = 17'd3600;
	localparam logic [16:0] MINUTE_SECS   = 17'd60;
	localparam logic [16:0] DAYS_PER_YEAR = 17'd365;
	localparam logic [14:0] YEAR_BIAS     = 15'd400;
	// shift from the March-based day count to 1970-01-01, including the day-1 term
	localparam int unsigned DAYS_BIAS     = 865566;

	typedef enum logic [2:0] {
		SFX_START,
		SFX_FRAC,
		SFX_DESIG,
		SFX_PREFIX,
		SFX_COLON,
		SFX_COMPACT
	} sfx_t;

	typedef enum logic [3:0] {
		ST_PARSE,
		ST_CHECK,
		ST_Q100,
		ST_Q400,
		ST_DAYS,
		ST_DSEC,
		ST_HOUR,
		ST_MIN,
		ST_DONE
	} seq_t;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	// one decimal digit into a 7-bit accumulator, wrapping
	function automatic logic [6:0] acc7(input logic [6:0] a, input logic [3:0] d);
		logic [10:0] t;
		t = ({4'b0, a} << 3) + ({4'b0, a} << 1) + 11'(d);
		return t[6:0];
	endfunction

	// day of a March-based year on which the month starts
	function automatic logic [8:0] month_doy(input logic [3:0] m);
		logic [8:0] r;
		case (m)
			4'd1:    r = 9'd306;
			4'd2:    r = 9'd337;
			4'd3:    r = 9'd0;
			4'd4:    r = 9'd31;
			4'd5:    r = 9'd61;
			4'd6:    r = 9'd92;
			4'd7:    r = 9'd122;
			4'd8:    r = 9'd153;
			4'd9:    r = 9'd184;
			4'd10:   r = 9'd214;
			4'd11:   r = 9'd245;
			4'd12:   r = 9'd275;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

// File: src/iso8601_timestamp_to_epoch.sv
// ISO 8601 UTC timestamp parser: byte stream in, validity flag and Unix seconds out.
// Depends on iso_ts_pkg for character codes, limits, sequencer states and tables.
// One byte is taken per cycle while a string streams in. After the last byte the
// block is busy with the check, six steps of the shared multiply-add unit and the
// output load on an accepted string, and with the check and the output load on a
// rejected one. The result waits in an output register while the next string
// streams in; if that register is still full at the load step, hold there until
// it drains. arst_n clears the parser, sequencer and output valid.
`default_nettype none

module iso8601_timestamp_to_epoch
	import iso_ts_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               s_axis_tvalid,
	output      logic               s_axis_tready,
	input  wire logic [7:0]         s_axis_tdata,   // [7:0] char_byte
	input  wire logic               s_axis_tlast,   // last
	output      logic               m_axis_tvalid,
	input  wire logic               m_axis_tready,
	output      logic [TDATA_W-1:0] m_axis_tdata,   // [38:0] epoch_seconds, [39] zero
	output      logic               m_axis_tuser    // [0] ok
);

	// parser state
	logic [4:0]  pos_q,  pos_d;
	logic [13:0] year_q, year_d;
	logic [6:0]  mon_q,  mon_d;
	logic [6:0]  day_q,  day_d;
	logic [6:0]  hour_q, hour_d;
	logic [6:0]  min_q,  min_d;
	logic [6:0]  sec_q,  sec_d;
	sfx_t        sfx_q,  sfx_d;
	logic [2:0]  oidx_q, oidx_d;
	logic        rej_q,  rej_d;

	// sequencer and conversion
	seq_t              st_q, st_d;
	logic              ok_q;
	logic [7:0]        q100_q;
	logic [7:0]        q400_q;
	logic [ACC_W-1:0]  acc_q;

	// output word
	logic               out_valid_q;
	logic               out_ok_q;
	logic [EPOCH_W-1:0] out_epoch_q;

	logic        word_in;
	logic        last_in;
	logic        out_free;
	logic        out_load;
	logic        parse_clr;
	logic        sfx_done;
	logic        ok_c;
	logic [3:0]  digit;
	logic [17:0] year_mul;
	logic [14:0] ys;

	// shared multiply-add unit
	logic signed [24:0] ua;
	logic [16:0]        ub;
	logic [ACC_W-1:0]   uadd;
	logic signed [42:0] uprod;
	logic signed [42:0] ures;

	assign s_axis_tready = (st_q == ST_PARSE);
	assign word_in       = s_axis_tvalid && s_axis_tready;
	assign last_in       = word_in && s_axis_tlast;
	assign out_free      = !out_valid_q || m_axis_tready;
	assign out_load      = (st_q == ST_DONE) && out_free;
	assign parse_clr     = out_load;

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_ok_q;
	assign m_axis_tdata  = {{(TDATA_W-EPOCH_W){1'b0}}, out_epoch_q};

	assign digit    = 4'(s_axis_tdata - CH_ZERO);
	assign year_mul = ({4'b0, year_q} << 3) + ({4'b0, year_q} << 1) + 18'(digit);

	// parser next state
	always_comb begin
		pos_d  = pos_q;
		year_d = year_q;
		mon_d  = mon_q;
		day_d  = day_q;
		hour_d = hour_q;
		min_d  = min_q;
		sec_d  = sec_q;
		sfx_d  = sfx_q;
		oidx_d = oidx_q;
		rej_d  = rej_q;
		if (parse_clr) begin
			pos_d  = '0;
			year_d = '0;
			mon_d  = '0;
			day_d  = '0;
			hour_d = '0;
			min_d  = '0;
			sec_d  = '0;
			sfx_d  = SFX_START;
			oidx_d = '0;
			rej_d  = 1'b0;
		end else if (word_in && !rej_q) begin
			if (pos_q < HEAD_LEN) begin
				pos_d = pos_q + 5'd1;
				if (pos_q == POS_DASH1 || pos_q == POS_DASH2) begin
					rej_d = (s_axis_tdata != CH_DASH);
				end else if (pos_q == POS_SEP) begin
					rej_d = !(s_axis_tdata == CH_T_UC || s_axis_tdata == CH_T_LC ||
						s_axis_tdata == CH_SPACE);
				end else if (pos_q == POS_COLON1 || pos_q == POS_COLON2) begin
					rej_d = (s_axis_tdata != CH_COLON);
				end else if (!is_digit(s_axis_tdata)) begin
					rej_d = 1'b1;
				end else if (pos_q < POS_DASH1) begin
					year_d = year_mul[13:0];
				end else if (pos_q < POS_DASH2) begin
					mon_d = acc7(mon_q, digit);
				end else if (pos_q < POS_SEP) begin
					day_d = acc7(day_q, digit);
				end else if (pos_q < POS_COLON1) begin
					hour_d = acc7(hour_q, digit);
				end else if (pos_q < POS_COLON2) begin
					min_d = acc7(min_q, digit);
				end else begin
					sec_d = acc7(sec_q, digit);
				end
			end else begin
				case (sfx_q)
					SFX_START, SFX_FRAC: begin
						if (s_axis_tdata == CH_DOT && sfx_q == SFX_START) begin
							sfx_d = SFX_FRAC;
						end else if (sfx_q == SFX_FRAC && is_digit(s_axis_tdata)) begin
							sfx_d = SFX_FRAC;
						end else if (s_axis_tdata == CH_Z_UC || s_axis_tdata == CH_Z_LC) begin
							sfx_d = SFX_DESIG;
						end else if (s_axis_tdata == CH_PLUS) begin
							sfx_d  = SFX_PREFIX;
							oidx_d = 3'd1;
						end else begin
							rej_d = 1'b1;
						end
					end
					SFX_PREFIX: begin
						if (oidx_q < OFS_PREFIX_END) begin
							if (s_axis_tdata == CH_ZERO) oidx_d = oidx_q + 3'd1;
							else rej_d = 1'b1;
						end else if (s_axis_tdata == CH_COLON) begin
							sfx_d  = SFX_COLON;
							oidx_d = OFS_AFTER_HH;
						end else if (s_axis_tdata == CH_ZERO) begin
							sfx_d  = SFX_COMPACT;
							oidx_d = OFS_AFTER_HH;
						end else begin
							rej_d = 1'b1;
						end
					end
					SFX_COLON: begin
						if (oidx_q < OFS_COLON_END && s_axis_tdata == CH_ZERO)
							oidx_d = oidx_q + 3'd1;
						else
							rej_d = 1'b1;
					end
					SFX_COMPACT: begin
						if (oidx_q < OFS_COMPACT_END && s_axis_tdata == CH_ZERO)
							oidx_d = oidx_q + 3'd1;
						else
							rej_d = 1'b1;
					end
					default: rej_d = 1'b1;  // nothing may follow a designator
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			year_q <= '0;
			mon_q  <= '0;
			day_q  <= '0;
			hour_q <= '0;
			min_q  <= '0;
			sec_q  <= '0;
			sfx_q  <= SFX_START;
			oidx_q <= '0;
			rej_q  <= 1'b0;
		end else begin
			pos_q  <= pos_d;
			year_q <= year_d;
			mon_q  <= mon_d;
			day_q  <= day_d;
			hour_q <= hour_d;
			min_q  <= min_d;
			sec_q  <= sec_d;
			sfx_q  <= sfx_d;
			oidx_q <= oidx_d;
			rej_q  <= rej_d;
		end
	end

	always_comb begin
		case (sfx_q)
			SFX_START, SFX_FRAC, SFX_DESIG: sfx_done = 1'b1;
			SFX_COLON:   sfx_done = (oidx_q == OFS_COLON_END);
			SFX_COMPACT: sfx_done = (oidx_q == OFS_COMPACT_END);
			default:     sfx_done = 1'b0;
		endcase
	end

	assign ok_c = !rej_q && (pos_q == HEAD_LEN) && sfx_done &&
		(mon_q >= 7'd1) && (mon_q <= MONTH_MAX) &&
		(day_q >= 7'd1) && (day_q <= DAY_MAX) &&
		(hour_q <= HOUR_MAX) && (min_q <= MINUTE_MAX) && (sec_q <= SECOND_MAX);

	// year shifted to start in March, biased by one 400-year cycle
	assign ys = 15'({1'b0, year_q}) + YEAR_BIAS - 15'(mon_q <= 7'd2);

	// operand selection for the multiply-add unit
	always_comb begin
		ua   = '0;
		ub   = '0;
		uadd = '0;
		case (st_q)
			ST_Q100: begin
				ua = signed'(25'(ys[14:2]));
				ub = RECIP_25;
			end
			ST_Q400: begin
				ua = signed'(25'(ys[14:4]));
				ub = RECIP_25;
			end
			ST_DAYS: begin
				ua   = signed'(25'(ys));
				ub   = DAYS_PER_YEAR;
				uadd = ACC_W'(ys[14:2]) - ACC_W'(q100_q) + ACC_W'(q400_q) +
					ACC_W'(month_doy(mon_q[3:0])) + ACC_W'(day_q) - ACC_W'(DAYS_BIAS);
			end
			ST_DSEC: begin
				ua   = signed'(acc_q[24:0]);
				ub   = DAY_SECS;
				uadd = ACC_W'(sec_q);
			end
			ST_HOUR: begin
				ua   = signed'(25'(hour_q));
				ub   = HOUR_SECS;
				uadd = acc_q;
			end
			ST_MIN: begin
				ua   = signed'(25'(min_q));
				ub   = MINUTE_SECS;
				uadd = acc_q;
			end
			default: begin
				ua   = '0;
				ub   = '0;
				uadd = '0;
			end
		endcase
	end

	assign uprod = 43'(ua) * 43'(signed'({1'b0, ub}));
	assign ures  = uprod + 43'(signed'(uadd));

	// sequencer next state
	always_comb begin
		st_d = st_q;
		case (st_q)
			ST_PARSE: if (last_in) st_d = ST_CHECK;
			ST_CHECK: st_d = ok_c ? ST_Q100 : ST_DONE;
			ST_Q100:  st_d = ST_Q400;
			ST_Q400:  st_d = ST_DAYS;
			ST_DAYS:  st_d = ST_DSEC;
			ST_DSEC:  st_d = ST_HOUR;
			ST_HOUR:  st_d = ST_MIN;
			ST_MIN:   st_d = ST_DONE;
			ST_DONE:  if (out_free) st_d = ST_PARSE;  // hold until the output register frees
			default:  st_d = ST_PARSE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_PARSE;
			ok_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (st_q == ST_CHECK) ok_q <= ok_c;
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			ST_Q100: q100_q <= ures[RECIP_SHIFT +: 8];
			ST_Q400: q400_q <= ures[RECIP_SHIFT +: 8];
			ST_DAYS, ST_DSEC, ST_HOUR, ST_MIN: acc_q <= ures[ACC_W-1:0];
			default: acc_q <= acc_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_ok_q    <= ok_q;
			out_epoch_q <= ok_q ? acc_q[EPOCH_W-1:0] : '0;
		end
	end

endmodule

`default_nettype wire

// File: src/iso_ts_checker.sv
// Port-level checker for the ISO 8601 timestamp parser, bound to its top level.
// Depends on iso_ts_pkg for the result word width.
`default_nettype none

module iso_ts_checker
	import iso_ts_pkg::*;
(
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               s_axis_tvalid,
	input wire logic               s_axis_tready,
	input wire logic               s_axis_tlast,
	input wire logic               m_axis_tvalid,
	input wire logic               m_axis_tready,
	input wire logic [TDATA_W-1:0] m_axis_tdata,
	input wire logic               m_axis_tuser
);

	// stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("result word changed while stalled");

	// rejected strings report zero seconds
	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
		else $error("rejected string carries nonzero seconds");

	// input stalls while the conversion runs after a last byte
	a_busy_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
		else $error("input taken during conversion");

	// a new result only shows up right after a busy cycle
	a_result_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> !$past(s_axis_tready))
		else $error("result appeared without a conversion");

endmodule

bind iso8601_timestamp_to_epoch iso_ts_checker u_iso_ts_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tlast  (s_axis_tlast),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

// File: verif/testbench.sv
// Stream testbench for the ISO 8601 timestamp parser: directed and random strings, random gaps.
// Depends on iso_ts_pkg and iso8601_timestamp_to_epoch; holds its own parser and epoch predictor.
`timescale 1ns / 100ps

module testbench
	import iso_ts_pkg::*;
();

	localparam int STALL_LIMIT  = 2000;
	localparam int BYTE_TARGET  = 1500;
	localparam int LONG_HOLD    = 400;
	localparam int HOLD_AT      = 40;
	localparam int PAUSE_AT     = 30;
	localparam int DRAIN_CYCLES = 20;

	typedef logic [7:0] char_q_t[$];

	typedef struct packed {
		logic               ok;
		logic [EPOCH_W-1:0] epoch;
	} stamp_result_t;

	class stamp_predictor;
		stamp_result_t pending_stamps[$];
		int            mismatches;
		logic [4:0]    head_count;
		logic [13:0]   year_val;
		logic [6:0]    month_val, day_val, hour_val, minute_val, second_val;
		sfx_t          sfx;
		logic [2:0]    ofs_seen;
		bit            dead;

		function new();
			mismatches = 0;
			restart();
		endfunction

		function void restart();
			head_count = '0;
			year_val   = '0;
			month_val  = '0;
			day_val    = '0;
			hour_val   = '0;
			minute_val = '0;
			second_val = '0;
			sfx        = SFX_START;
			ofs_seen   = '0;
			dead       = 1'b0;
		endfunction

		function bit numeral(logic [7:0] c);
			return c >= CH_ZERO && c <= CH_NINE;
		endfunction

		function logic [6:0] shift_in(logic [6:0] a, logic [7:0] c);
			return 7'(int'(a) * 10 + int'(c - CH_ZERO));
		endfunction

		// days from 1970-01-01 to the first of month m of year y
		function longint first_day_of_month(longint y, longint m);
			longint ys, era, yoe, mp, doy, doe;
			ys  = y - ((m <= 2) ? 1 : 0) + 400;
			era = ys / 400;
			yoe = ys - era * 400;
			mp  = (m + 9) % 12;
			doy = (153 * mp + 2) / 5;
			doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
			return era * 146097 + doe - 719468 - 146097;
		endfunction

		function void head_char(logic [7:0] c);
			if (head_count == POS_DASH1 || head_count == POS_DASH2) begin
				if (c != CH_DASH) dead = 1'b1;
			end else if (head_count == POS_SEP) begin
				if (c != CH_T_UC && c != CH_T_LC && c != CH_SPACE) dead = 1'b1;
			end else if (head_count == POS_COLON1 || head_count == POS_COLON2) begin
				if (c != CH_COLON) dead = 1'b1;
			end else if (!numeral(c)) begin
				dead = 1'b1;
			end else if (head_count < POS_DASH1) begin
				year_val = 14'(int'(year_val) * 10 + int'(c - CH_ZERO));
			end else if (head_count < POS_DASH2) begin
				month_val = shift_in(month_val, c);
			end else if (head_count < POS_SEP) begin
				day_val = shift_in(day_val, c);
			end else if (head_count < POS_COLON1) begin
				hour_val = shift_in(hour_val, c);
			end else if (head_count < POS_COLON2) begin
				minute_val = shift_in(minute_val, c);
			end else begin
				second_val = shift_in(second_val, c);
			end
			head_count = head_count + 5'd1;
		endfunction

		function void suffix_char(logic [7:0] c);
			case (sfx)
				SFX_START, SFX_FRAC: begin
					if (c == CH_DOT && sfx == SFX_START) sfx = SFX_FRAC;
					else if (sfx == SFX_FRAC && numeral(c)) ;
					else if (c == CH_Z_UC || c == CH_Z_LC) sfx = SFX_DESIG;
					else if (c == CH_PLUS) begin
						sfx = SFX_PREFIX;
						ofs_seen = 3'd1;
					end else dead = 1'b1;
				end
				SFX_PREFIX: begin
					if (ofs_seen < OFS_PREFIX_END) begin
						if (c == CH_ZERO) ofs_seen = ofs_seen + 3'd1;
						else dead = 1'b1;
					end else if (c == CH_COLON) begin
						sfx = SFX_COLON;
						ofs_seen = OFS_AFTER_HH;
					end else if (c == CH_ZERO) begin
						sfx = SFX_COMPACT;
						ofs_seen = OFS_AFTER_HH;
					end else dead = 1'b1;
				end
				SFX_COLON: begin
					if (ofs_seen < OFS_COLON_END && c == CH_ZERO) ofs_seen = ofs_seen + 3'd1;
					else dead = 1'b1;
				end
				SFX_COMPACT: begin
					if (ofs_seen < OFS_COMPACT_END && c == CH_ZERO) ofs_seen = ofs_seen + 3'd1;
					else dead = 1'b1;
				end
				// anything after a designator ends the string's chances
				default: dead = 1'b1;
			endcase
		endfunction

		function void absorb_char(logic [7:0] c, bit is_last);
			stamp_result_t res;
			bit            tail_ok;
			longint        secs;
			if (!dead) begin
				if (head_count < HEAD_LEN) head_char(c);
				else suffix_char(c);
			end
			if (!is_last) return;
			tail_ok = sfx <= SFX_DESIG ||
				(sfx == SFX_COLON && ofs_seen == OFS_COLON_END) ||
				(sfx == SFX_COMPACT && ofs_seen == OFS_COMPACT_END);
			res.ok = !dead && head_count == HEAD_LEN && tail_ok &&
				month_val >= 7'd1 && month_val <= MONTH_MAX &&
				day_val >= 7'd1 && day_val <= DAY_MAX &&
				hour_val <= HOUR_MAX && minute_val <= MINUTE_MAX && second_val <= SECOND_MAX;
			secs = 0;
			if (res.ok) begin
				secs = (first_day_of_month(longint'(year_val), longint'(month_val)) +
					longint'(day_val) - 1) * 86400 + longint'(hour_val) * 3600 +
					longint'(minute_val) * 60 + longint'(second_val);
			end
			res.epoch = secs[EPOCH_W-1:0];
			pending_stamps.push_back(res);
			restart();
		endfunction

		function void report(string msg);
			mismatches++;
			if (mismatches <= 10) $display("mismatch: %s", msg);
		endfunction

		function void check_stamp(logic ok, logic [TDATA_W-1:0] data);
			stamp_result_t want;
			if (pending_stamps.size() == 0) begin
				report($sformatf("word with nothing pending: ok=%0b epoch=%0d", ok,
					$signed(data[EPOCH_W-1:0])));
				return;
			end
			want = pending_stamps.pop_front();
			if (ok !== want.ok || data[EPOCH_W-1:0] !== want.epoch ||
					data[TDATA_W-1:EPOCH_W] !== '0) begin
				report($sformatf("ok exp %0b got %0b, epoch exp %0d got %0d, pad got %b",
					want.ok, ok, $signed(want.epoch), $signed(data[EPOCH_W-1:0]),
					data[TDATA_W-1:EPOCH_W]));
			end
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               s_axis_tvalid = 1'b0;
	logic               s_axis_tready;
	logic [7:0]         s_axis_tdata = '0;
	logic               s_axis_tlast = 1'b0;
	logic               m_axis_tvalid;
	logic               m_axis_tready = 1'b0;
	logic [TDATA_W-1:0] m_axis_tdata;
	logic               m_axis_tuser;

	stamp_predictor board = new();
	int             sent_bytes = 0;
	int             idle_cycles = 0;

	iso8601_timestamp_to_epoch uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always #2 clk = ~clk;

	// sample at the falling edge, where every driven value is settled
	always @(negedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

	function automatic char_q_t to_chars(input string s);
		char_q_t q;
		for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
		return q;
	endfunction

	// mostly in range, now and then any two-digit value
	function automatic int field_value(input int lo, input int hi);
		return ($urandom_range(0, 9) == 0) ? $urandom_range(0, 99) : $urandom_range(lo, hi);
	endfunction

	function automatic char_q_t random_chars();
		char_q_t q;
		string   s, sep;
		int      n, cut;
		case ($urandom_range(0, 2))
			0: sep = "T";
			1: sep = "t";
			default: sep = " ";
		endcase
		s = $sformatf("%04d-%02d-%02d%s%02d:%02d:%02d", $urandom_range(0, 9999),
			field_value(1, 12), field_value(1, 31), sep, field_value(0, 23),
			field_value(0, 59), field_value(0, 60));
		case ($urandom_range(0, 5))
			0, 1, 2: ;
			3, 4: n = $urandom_range(0, 6);
			default: n = $urandom_range(7, 30);
		endcase
		if ($urandom_range(0, 5) >= 3) begin
			n = ($urandom_range(0, 5) == 5) ? $urandom_range(7, 30) : $urandom_range(0, 6);
			s = {s, "."};
			repeat (n) s = {s, $sformatf("%0d", $urandom_range(0, 9))};
		end
		case ($urandom_range(0, 4))
			0: ;
			1: s = {s, "Z"};
			2: s = {s, "z"};
			3: s = {s, "+00:00"};
			default: s = {s, "+0000"};
		endcase
		q = to_chars(s);
		case ($urandom_range(0, 9))
			0: q[$urandom_range(0, q.size() - 1)] = 8'($urandom_range(0, 255));
			1: begin
				cut = $urandom_range(0, q.size() - 2);
				q = q[0:cut];
			end
			2: repeat ($urandom_range(1, 3)) q.push_back(8'($urandom_range(0, 255)));
			3: begin
				q.delete();
				repeat ($urandom_range(1, 24)) q.push_back(8'($urandom_range(0, 255)));
			end
			default: ;
		endcase
		return q;
	endfunction

	task automatic send_chars(input char_q_t chars, input bit eager);
		int gap;
		for (int i = 0; i < chars.size(); i++) begin
			gap = eager ? 0 : $urandom_range(0, 15);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			s_axis_tvalid <= 1'b1;
			s_axis_tdata  <= chars[i];
			s_axis_tlast  <= (i == chars.size() - 1);
			do @(negedge clk); while (!s_axis_tready);
			board.absorb_char(chars[i], i == chars.size() - 1);
			sent_bytes++;
			@(posedge clk);
		end
	endtask

	task automatic send_text(input string s);
		send_chars(to_chars(s), $urandom_range(0, 1));
	endtask

	task automatic wait_until_drained();
		s_axis_tvalid <= 1'b0;
		while (board.pending_stamps.size() != 0) @(negedge clk);
		@(posedge clk);
	endtask

	initial begin : drain_results
		int stall;
		int taken;
		bit eager;
		taken = 0;
		eager = 1'b0;
		@(posedge clk);
		forever begin
			if (taken % 32 == 0) eager = ($urandom_range(0, 2) == 0);
			stall = (taken == HOLD_AT) ? LONG_HOLD : (eager ? 0 : $urandom_range(0, 15));
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(negedge clk); while (!m_axis_tvalid);
			board.check_stamp(m_axis_tuser, m_axis_tdata);
			taken++;
			@(posedge clk);
		end
	end

	initial begin : run_stimulus
		char_q_t chars;
		int      strings;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_text("1970-01-01T00:00:00Z");
		send_text("0000-01-01T00:00:00");
		send_text("9999-12-31T23:59:60z");
		send_text("2000-02-29t12:34:56.789+00:00");
		send_text("2024-06-15 08:09:10.+0000");
		send_text("2021-02-31T23:59:59");
		send_text("2020-00-10T00:00:00");
		send_text("2020-13-10T00:00:00");
		send_text("2020-05-00T00:00:00");
		send_text("2020-05-32T00:00:00");
		send_text("2020-05-05T24:00:00");
		send_text("2020-05-05T00:60:00");
		send_text("2020-05-05T00:00:61");
		send_text("2020");
		send_text("2020-05-05T00:00:00Zx");
		send_text("2020-05-05T00:00:00+00:0");
		send_text("2020-05-05T00:00:00+000");
		send_text("2020-05-05T00:00:00+01:00");
		send_text("2020-05-05T00:00:00.1.2");
		// zero bytes, alone and inside the head, and a stray high byte at the separator
		chars = '{8'h00};
		send_chars(chars, 1'b0);
		chars = to_chars("2020-01-01T00:00:0");
		chars.push_back(8'h00);
		send_chars(chars, 1'b1);
		chars = to_chars("1970-01-01");
		chars.push_back(8'hFF);
		chars = {chars, to_chars("00:00:00")};
		send_chars(chars, 1'b0);

		strings = 0;
		while (sent_bytes < BYTE_TARGET) begin
			if (strings == PAUSE_AT) wait_until_drained();
			send_chars(random_chars(), $urandom_range(0, 3) == 0);
			strings++;
		end

		wait_until_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (board.mismatches == 0 && board.pending_stamps.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
